// ----- hdl/wfmhq_pkg.sv -----
// Package with the shared constants and types of the wide fanout heap queue.
package wfmhq_pkg;
    localparam int CAPACITY = 1024;
    localparam int FANOUT = 8;
    localparam int HALF = FANOUT / 2;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = $clog2(FANOUT);
    localparam logic [31:0] KEY_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_PUSH_DONE = 2'd0,
        ST_PUSH_FULL = 2'd1,
        ST_POP_DONE  = 2'd2,
        ST_POP_EMPTY = 2'd3
    } status_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP = 1'b1;
endpackage

// ----- hdl/wfmhq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module wfmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/wide_fanout_min_heap_queue_unit.sv -----
// Top level of the wide fanout min heap queue: sequencer around key and payload memories.
//
//   channel  | valid     | stall     | payload
//   input    | in_valid  | in_stall  | op, payload, key
//   output   | out_valid | out_stall | status, out_payload
//
// One word is handled at a time; the sequencer reads one slot per cycle.
// A push first fills a new set with empty slots when the filled bound is reached, then
// moves the new entry up one level at a time; a pop scans one set per level (slot reads,
// then a decision) and moves each smaller entry up into the hole.
// Reset clears the counters and control registers but not the memories, which need no clearing.
// A finished result waits in the output register while the output is stalled; the next
// word is taken meanwhile and its result waits until the output register is free.
module wide_fanout_min_heap_queue_unit
    import wfmhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] payload,
    input  logic [31:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] out_payload
);
    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_UPRD, S_UPCMP, S_UPEND,
        S_PRD, S_PLAST, S_SCAN, S_SDEC, S_DMOVE, S_DEND, S_OUT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg, bound_reg;
    logic [31:0] k_reg, p_reg, res_reg;
    logic [AW:0] node_reg, par_reg, base_reg, hole_reg;
    logic have_hole_reg;
    logic [OW:0] idx_reg;
    logic [31:0] ak_reg, bk_reg;
    logic [AW:0] aa_reg, ba_reg;
    logic [1:0] status_reg;
    logic out_valid_reg;
    logic [1:0] wstat_reg;
    logic [31:0] wres_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wkey, wpay, rkey, rpay;
    logic [AW:0] raddr_w;
    logic [AW:0] nsets;

    wfmhq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wkey), .raddr(raddr), .rdata(rkey));
    wfmhq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_pay (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wpay), .raddr(raddr), .rdata(rpay));

    logic [AW:0] last_w, min_w;
    logic [31:0] min_k;
    logic in_range_r;
    logic [AW:0] raddr_q;

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign out_payload = res_reg;
    assign raddr = raddr_w[AW-1:0];
    assign last_w = {1'b0, count_reg[AW-1:0]};
    assign nsets = (AW+1)'((count_reg + CW'(FANOUT - 1)) / CW'(FANOUT));
    assign in_range_r = (raddr_q < (AW+1)'(CAPACITY));
    assign min_w = (ak_reg < bk_reg) ? aa_reg : ba_reg;
    assign min_k = (ak_reg < bk_reg) ? ak_reg : bk_reg;

    always_comb
    begin
        raddr_w = '0;
        case (state_reg)
            S_UPRD:  raddr_w = par_reg - 1'b1;
            S_PRD:   raddr_w = last_w;
            S_SCAN:  raddr_w = base_reg + (AW+1)'(idx_reg);
            S_SDEC:  raddr_w = min_w;
            default: raddr_w = '0;
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wkey = KEY_MAX;
        wpay = '0;
        case (state_reg)
            S_FILL:
            begin
                we = (bound_reg + CW'(idx_reg)) < CW'(CAPACITY);
                waddr = AW'(bound_reg + CW'(idx_reg));
            end
            S_UPCMP:
            begin
                we = (k_reg < rkey);
                waddr = node_reg[AW-1:0];
                wkey = rkey;
                wpay = rpay;
            end
            S_UPEND:
            begin
                we = 1'b1;
                waddr = node_reg[AW-1:0];
                wkey = k_reg;
                wpay = p_reg;
            end
            S_PLAST:
            begin
                we = 1'b1;
                waddr = last_w[AW-1:0];
                wkey = KEY_MAX;
                wpay = rpay;
            end
            S_DMOVE:
            begin
                we = have_hole_reg;
                waddr = hole_reg[AW-1:0];
                wkey = rkey;
                wpay = rpay;
            end
            S_DEND:
            begin
                we = have_hole_reg;
                waddr = hole_reg[AW-1:0];
                wkey = k_reg;
                wpay = p_reg;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bound_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= ST_PUSH_DONE;
            res_reg <= '0;
            wstat_reg <= ST_PUSH_DONE;
            wres_reg <= '0;
            k_reg <= '0;
            p_reg <= '0;
            node_reg <= '0;
            par_reg <= '0;
            base_reg <= '0;
            hole_reg <= '0;
            have_hole_reg <= 1'b0;
            idx_reg <= '0;
            ak_reg <= '0;
            bk_reg <= '0;
            aa_reg <= '0;
            ba_reg <= '0;
            raddr_q <= '0;
        end
        else
        begin
            raddr_q <= raddr_w;
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
                status_reg <= wstat_reg;
                res_reg <= wres_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        k_reg <= key;
                        p_reg <= payload;
                        idx_reg <= '0;
                        if (op == OP_PUSH)
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                wstat_reg <= ST_PUSH_FULL;
                                wres_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                node_reg <= last_w;
                                par_reg <= last_w / (AW+1)'(FANOUT);
                                state_reg <= (count_reg >= bound_reg) ? S_FILL : S_UPRD;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            wstat_reg <= ST_POP_EMPTY;
                            wres_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            count_reg <= count_reg - 1'b1;
                            state_reg <= S_PRD;
                        end
                    end
                end
                S_FILL:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (OW+1)'(FANOUT - 1))
                    begin
                        bound_reg <= bound_reg + CW'(FANOUT);
                        state_reg <= S_UPRD;
                    end
                end
                S_UPRD:
                begin
                    state_reg <= (par_reg == '0) ? S_UPEND : S_UPCMP;
                end
                S_UPCMP:
                begin
                    if (k_reg < rkey)
                    begin
                        node_reg <= par_reg - 1'b1;
                        par_reg <= (par_reg - 1'b1) / (AW+1)'(FANOUT);
                        state_reg <= S_UPRD;
                    end
                    else
                    begin
                        state_reg <= S_UPEND;
                    end
                end
                S_UPEND:
                begin
                    count_reg <= count_reg + 1'b1;
                    wstat_reg <= ST_PUSH_DONE;
                    wres_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_PRD:
                begin
                    state_reg <= S_PLAST;
                end
                S_PLAST:
                begin
                    k_reg <= rkey;
                    p_reg <= rpay;
                    wres_reg <= rpay;
                    have_hole_reg <= 1'b0;
                    base_reg <= '0;
                    idx_reg <= '0;
                    state_reg <= (nsets == '0) ? S_DEND : S_SCAN;
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg != '0)
                    begin
                        if (idx_reg - 1'b1 < (OW+1)'(HALF))
                        begin
                            if (idx_reg == (OW+1)'(1) ||
                                (in_range_r ? rkey : KEY_MAX) < ak_reg)
                            begin
                                ak_reg <= in_range_r ? rkey : KEY_MAX;
                                aa_reg <= raddr_q;
                            end
                        end
                        else if (idx_reg - 1'b1 == (OW+1)'(HALF) ||
                                 (in_range_r ? rkey : KEY_MAX) < bk_reg)
                        begin
                            bk_reg <= in_range_r ? rkey : KEY_MAX;
                            ba_reg <= raddr_q;
                        end
                    end
                    if (idx_reg == (OW+1)'(FANOUT))
                    begin
                        state_reg <= S_SDEC;
                    end
                end
                S_SDEC:
                begin
                    if (k_reg <= min_k)
                    begin
                        state_reg <= S_DEND;
                    end
                    else
                    begin
                        state_reg <= S_DMOVE;
                    end
                end
                S_DMOVE:
                begin
                    if (!have_hole_reg)
                    begin
                        wres_reg <= rpay;
                    end
                    have_hole_reg <= 1'b1;
                    hole_reg <= min_w;
                    base_reg <= (min_w + 1'b1) * (AW+1)'(FANOUT);
                    idx_reg <= '0;
                    state_reg <= ((min_w + 1'b1) < nsets) ? S_SCAN : S_DEND;
                end
                S_DEND:
                begin
                    wstat_reg <= ST_POP_DONE;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- verif/heap_queue_checker.sv -----
// Checker that predicts the heap queue results and compares them with the block outputs.
`timescale 1ns / 1ps
module heap_queue_checker
    import wfmhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [31:0] payload,
    input  logic [31:0] key,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [31:0] out_payload,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        status_t     st;
        logic [31:0] pay;
    } heap_result_t;

    logic [31:0] heap_key [CAPACITY];
    logic [31:0] heap_pay [CAPACITY];
    int unsigned count_q;
    int unsigned boundary_q;
    heap_result_t result_q [$];

    function automatic logic [31:0] key_at(int unsigned idx);
        return idx < CAPACITY ? heap_key[idx] : KEY_MAX;
    endfunction

    function automatic logic [31:0] pay_at(int unsigned idx);
        return idx < CAPACITY ? heap_pay[idx] : 32'd0;
    endfunction

    task automatic put_slot(int unsigned idx, logic [31:0] k, logic [31:0] p);
        if (idx < CAPACITY)
        begin
            heap_key[idx] = k;
            heap_pay[idx] = p;
        end
    endtask

    function automatic int unsigned min_offset(int unsigned base);
        int unsigned a;
        int unsigned b;
        a = 0;
        b = HALF;
        for (int unsigned i = 0; i < HALF; i++)
            if (key_at(base + i) < key_at(base + a))
                a = i;
        for (int unsigned i = HALF; i < FANOUT; i++)
            if (key_at(base + i) < key_at(base + b))
                b = i;
        return key_at(base + a) < key_at(base + b) ? a : b;
    endfunction

    task automatic predict_word(logic o, logic [31:0] p_in, logic [31:0] k_in);
        int unsigned node;
        int unsigned par;
        int unsigned nsets;
        int unsigned set_i;
        int unsigned idx;
        int unsigned hole;
        bit have_hole;
        logic [31:0] tk;
        logic [31:0] tp;
        logic [31:0] res;
        heap_result_t r;
        if (o == OP_PUSH)
        begin
            if (count_q >= CAPACITY)
            begin
                r = '{ST_PUSH_FULL, 32'd0};
            end
            else
            begin
                if (count_q >= boundary_q)
                begin
                    for (int unsigned i = 0; i < FANOUT; i++)
                        put_slot(boundary_q + i, KEY_MAX, 32'd0);
                    boundary_q += FANOUT;
                end
                node = count_q;
                par = node / FANOUT;
                while (par != 0 && k_in < key_at(par - 1))
                begin
                    par -= 1;
                    put_slot(node, key_at(par), pay_at(par));
                    node = par;
                    par /= FANOUT;
                end
                put_slot(node, k_in, p_in);
                count_q += 1;
                r = '{ST_PUSH_DONE, 32'd0};
            end
        end
        else if (count_q == 0)
        begin
            r = '{ST_POP_EMPTY, 32'd0};
        end
        else
        begin
            count_q -= 1;
            tk = key_at(count_q);
            tp = pay_at(count_q);
            if (count_q < CAPACITY)
                heap_key[count_q] = KEY_MAX;
            nsets = (count_q + FANOUT - 1) / FANOUT;
            res = tp;
            have_hole = 0;
            hole = 0;
            set_i = 0;
            while (set_i < nsets)
            begin
                idx = FANOUT * set_i + min_offset(FANOUT * set_i);
                if (tk <= key_at(idx))
                    break;
                if (have_hole)
                    put_slot(hole, key_at(idx), pay_at(idx));
                else
                    res = pay_at(idx);
                have_hole = 1;
                hole = idx;
                set_i = idx + 1;
            end
            if (have_hole)
                put_slot(hole, tk, tp);
            r = '{ST_POP_DONE, res};
        end
        result_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t e;
        if (!rst_n)
        begin
            count_q = 0;
            boundary_q = 0;
            errors = 0;
            result_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected word status %0d payload %h",
                             $time, status, out_payload);
                    errors++;
                end
                else
                begin
                    e = result_q.pop_front();
                    if (status !== e.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                        errors++;
                    end
                    if (out_payload !== e.pay)
                    begin
                        $display("%0t: out_payload expected %h actual %h",
                                 $time, e.pay, out_payload);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_word(op, payload, key);
            pending = result_q.size();
        end
    end
endmodule

// ----- verif/testbench.sv -----
// Top of the heap queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import wfmhq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [31:0] payload;
    logic [31:0] key;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] out_payload;
    int          errors;
    int          pending;
    int          idle_cycles;
    bit          hold_output;
    bit          random_stall;

    wide_fanout_min_heap_queue_unit dut (.*);
    heap_queue_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    endfunction

    task automatic send_word(logic o, logic [31:0] p, logic [31:0] k, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if ($urandom_range(0, 2) == 0)
            g = 0;
        if (g > 0)
        begin
            in_valid <= 0;
            op <= 1'($urandom);
            payload <= $urandom;
            key <= $urandom;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1;
        op <= o;
        payload <= p;
        key <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        op <= 1'($urandom);
        payload <= $urandom;
        key <= $urandom;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return KEY_MAX;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    always @(negedge clk)
    begin
        int s;
        if (!rst_n || hold_output)
            out_stall <= hold_output;
        else if (random_stall)
        begin
            if (s > 0)
            begin
                s--;
                out_stall <= 1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                s = gap_len();
                out_stall <= (s > 0);
            end
            else
                out_stall <= 0;
        end
        else
            out_stall <= 0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        int n;
        rst_n = 0;
        in_valid = 0;
        op = 0;
        payload = 0;
        key = 0;
        out_stall = 0;
        idle_cycles = 0;
        hold_output = 0;
        random_stall = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_word(OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_word(OP_PUSH, 32'hFFFF_FFFF, KEY_MAX, 0);
        send_word(OP_PUSH, 32'h0, 32'h0, 0);
        for (int i = 0; i < 10; i++)
            send_word(OP_PUSH, 32'h100 + i, 32'd5, 0);
        send_word(OP_PUSH, 32'hAAAA_5555, 32'h8000_0000, 0);
        for (int i = 0; i < 11; i++)
            send_word(OP_POP, 32'h0, 32'h0, 0);
        wait_drained();

        random_stall = 1;
        for (int i = 0; i < 1030; i++)
            send_word(OP_PUSH, $urandom, pick_key(), i > 900);
        for (int i = 0; i < 40; i++)
            send_word(1'($urandom_range(0, 1)), $urandom, pick_key(), 1);
        for (int i = 0; i < 300; i++)
            send_word(OP_POP, $urandom, $urandom, i > 220);
        wait_drained();

        fork
            begin
                hold_output = 1;
                repeat (400) @(negedge clk);
                hold_output = 0;
            end
            for (int i = 0; i < 6; i++)
                send_word(OP_PUSH, $urandom, pick_key(), 0);
        join
        wait_drained();

        for (int i = 0; i < 250; i++)
        begin
            n = $urandom_range(0, 99);
            send_word(n < 55 ? OP_PUSH : OP_POP, $urandom, pick_key(), 1);
        end
        wait_drained();
        repeat (200) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/wfmhq_pkg.sv
hdl/wfmhq_ram.sv
hdl/wide_fanout_min_heap_queue_unit.sv
verif/heap_queue_checker.sv
verif/testbench.sv
